// ===== rtl/core/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbc_pkg: shared definitions for the LRU block cache
// Parameter defaults, register reset value and sequencer state codes.
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int DEPTH_DEFAULT        = 64;
    localparam int DATA_BITS_DEFAULT    = 64;
    localparam int FILE_ID_BITS_DEFAULT = 32;

    localparam logic [6:0] CAPACITY_RESET = 7'd64;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_PASS   = 5'b00100,
        ST_INSERT = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

endpackage

// ===== rtl/core/lru_block_cache.sv =====
// ----------------------------------------------------------------------------
// lru_block_cache: fully associative LRU cache keyed by file, offset, frame
// Keys, payload words and recency ranks sit in synchronous memories that a
// sequencer walks entry by entry.
// ----------------------------------------------------------------------------
// A transaction starts when start is high while busy is low. The result is
// shown for exactly one cycle with done high and cannot be held off; the
// counters stay on their ports until the next result. Each transaction first
// scans all DEPTH entries, one memory read per cycle, to find the key. A get
// hit or a put with nonzero capacity then runs a second pass over the rank
// memory that promotes a hit entry and ages the more recent ones, or on a put
// miss evicts the oldest entries as needed, ages the rest and frees a slot; a
// put then writes its payload in the insert state. A put with capacity zero
// ends after the scan. The rank memory has a single read port.
module lru_block_cache #(
    parameter int DEPTH        = lbc_pkg::DEPTH_DEFAULT,
    parameter int DATA_BITS    = lbc_pkg::DATA_BITS_DEFAULT,
    parameter int FILE_ID_BITS = lbc_pkg::FILE_ID_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [31:0] file_id,
    input  logic [63:0] offset,
    input  logic [31:0] frame_bytes,
    input  logic [63:0] write_data,
    output logic        done,
    output logic        hit,
    output logic [63:0] read_data,
    output logic [6:0]  evicted_now,
    output logic [31:0] hit_count,
    output logic [31:0] miss_count,
    output logic [31:0] evict_count
);

    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (CNT_W > 7) ? CNT_W : 7;
    localparam int FW    = (FILE_ID_BITS < 32) ? FILE_ID_BITS : 32;
    localparam int DW    = DATA_BITS;

    // Storage
    logic [FW-1:0] file_mem   [DEPTH];
    logic [63:0]   offset_mem [DEPTH];
    logic [31:0]   frame_mem  [DEPTH];
    logic [DW-1:0] data_mem   [DEPTH];
    logic [IW-1:0] age_mem    [DEPTH];
    logic          valid_reg  [DEPTH];

    logic [FW-1:0] file_q;
    logic [63:0]   offset_q;
    logic [31:0]   frame_q;
    logic [DW-1:0] data_q;
    logic [IW-1:0] age_q;

    lbc_pkg::state_t state_reg, state_next;

    logic [6:0]       capacity_reg;
    logic             mode_reg;
    logic [FW-1:0]    file_reg;
    logic [63:0]      offset_reg;
    logic [31:0]      frame_reg;
    logic [DW-1:0]    wdata_reg;

    logic [IW-1:0]    ptr_reg, ptr_next;
    logic             issued_reg, issued_next;
    logic             pend_reg, pend_next;
    logic [IW-1:0]    tag_reg, tag_next;

    logic             found_reg, found_next;
    logic [IW-1:0]    hidx_reg, hidx_next;
    logic [IW-1:0]    hage_reg, hage_next;
    logic [DW-1:0]    hdata_reg, hdata_next;
    logic             free_found_reg, free_found_next;
    logic [IW-1:0]    free_idx_reg, free_idx_next;
    logic [CNT_W-1:0] evcnt_reg, evcnt_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [31:0]      hit_total_reg, hit_total_next;
    logic [31:0]      miss_total_reg, miss_total_next;
    logic [31:0]      evict_total_reg, evict_total_next;
    logic             res_hit_reg, res_hit_next;
    logic [DW-1:0]    res_data_reg, res_data_next;
    logic [6:0]       res_ev_reg, res_ev_next;

    logic             age_we;
    logic [IW-1:0]    age_waddr;
    logic [IW-1:0]    age_wdata;
    logic             key_we;
    logic             data_we;
    logic [IW-1:0]    ins_addr;
    logic             clr_valid;
    logic             set_valid;

    logic [CW-1:0]    cap_w;
    logic [CW-1:0]    capm1;
    logic             match;
    logic             last_tag;
    logic             evict_now;
    logic             cur_valid;

    // Effective capacity, clipped to the depth
    assign cap_w = (CW'(capacity_reg) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(capacity_reg);
    assign capm1 = cap_w - CW'(1);

    assign cur_valid = valid_reg[tag_reg];
    assign match     = cur_valid && (file_q == file_reg) && (offset_q == offset_reg)
                       && (frame_q == frame_reg);
    assign last_tag  = (tag_reg == IW'(DEPTH - 1));
    assign evict_now = cur_valid && (CW'(count_reg) > capm1) && (CW'(age_q) >= capm1);
    assign ins_addr  = found_reg ? hidx_reg : free_idx_reg;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lbc_pkg::CAPACITY_RESET;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_data;
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            mode_reg   <= mode;
            file_reg   <= file_id[FW-1:0];
            offset_reg <= offset;
            frame_reg  <= frame_bytes;
            wdata_reg  <= write_data[DW-1:0];
        end
    end

    // Memory reads, one address per cycle
    always_ff @(posedge clk)
    begin
        file_q   <= file_mem[ptr_reg];
        offset_q <= offset_mem[ptr_reg];
        frame_q  <= frame_mem[ptr_reg];
        data_q   <= data_mem[ptr_reg];
        age_q    <= age_mem[ptr_reg];
    end

    // Memory writes
    always_ff @(posedge clk)
    begin
        if (age_we)
        begin
            age_mem[age_waddr] <= age_wdata;
        end
        if (key_we)
        begin
            file_mem[ins_addr]   <= file_reg;
            offset_mem[ins_addr] <= offset_reg;
            frame_mem[ins_addr]  <= frame_reg;
        end
        if (data_we)
        begin
            data_mem[ins_addr] <= wdata_reg;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (clr_valid)
            begin
                valid_reg[tag_reg] <= 1'b0;
            end
            if (set_valid)
            begin
                valid_reg[ins_addr] <= 1'b1;
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        ptr_next         = ptr_reg;
        issued_next      = issued_reg;
        pend_next        = 1'b0;
        tag_next         = ptr_reg;
        found_next       = found_reg;
        hidx_next        = hidx_reg;
        hage_next        = hage_reg;
        hdata_next       = hdata_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        evcnt_next       = evcnt_reg;
        count_next       = count_reg;
        hit_total_next   = hit_total_reg;
        miss_total_next  = miss_total_reg;
        evict_total_next = evict_total_reg;
        res_hit_next     = res_hit_reg;
        res_data_next    = res_data_reg;
        res_ev_next      = res_ev_reg;
        age_we           = 1'b0;
        age_waddr        = tag_reg;
        age_wdata        = age_q;
        key_we           = 1'b0;
        data_we          = 1'b0;
        clr_valid        = 1'b0;
        set_valid        = 1'b0;

        // Walk the addresses while a pass is running
        if ((state_reg == lbc_pkg::ST_SCAN || state_reg == lbc_pkg::ST_PASS) && !issued_reg)
        begin
            pend_next = 1'b1;
            if (ptr_reg == IW'(DEPTH - 1))
            begin
                issued_next = 1'b1;
            end
            else
            begin
                ptr_next = ptr_reg + IW'(1);
            end
        end

        unique case (state_reg)
            lbc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next      = lbc_pkg::ST_SCAN;
                    ptr_next        = '0;
                    issued_next     = 1'b0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    evcnt_next      = '0;
                end
            end
            lbc_pkg::ST_SCAN:
            begin
                if (pend_reg)
                begin
                    if (match && !found_reg)
                    begin
                        found_next = 1'b1;
                        hidx_next  = tag_reg;
                        hage_next  = age_q;
                        hdata_next = data_q;
                    end
                    if (last_tag)
                    begin
                        ptr_next    = '0;
                        issued_next = 1'b0;
                        pend_next   = 1'b0;
                        res_hit_next  = found_next;
                        res_data_next = '0;
                        res_ev_next   = '0;
                        if (!mode_reg)
                        begin
                            if (found_next)
                            begin
                                state_next = lbc_pkg::ST_PASS;
                            end
                            else
                            begin
                                miss_total_next = miss_total_reg + 32'd1;
                                state_next      = lbc_pkg::ST_DONE;
                            end
                        end
                        else if (cap_w == '0)
                        begin
                            res_hit_next = 1'b0;
                            state_next   = lbc_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = lbc_pkg::ST_PASS;
                        end
                    end
                end
            end
            lbc_pkg::ST_PASS:
            begin
                if (pend_reg)
                begin
                    age_we = 1'b1;
                    if (found_reg)
                    begin
                        // Promote the hit entry, age the more recent ones
                        if (tag_reg == hidx_reg)
                        begin
                            age_wdata = '0;
                        end
                        else if (cur_valid && age_q < hage_reg)
                        begin
                            age_wdata = age_q + IW'(1);
                        end
                    end
                    else
                    begin
                        // Drop the oldest entries, age the rest, find a slot
                        if (evict_now)
                        begin
                            clr_valid  = 1'b1;
                            age_wdata  = '0;
                            evcnt_next = evcnt_reg + CNT_W'(1);
                        end
                        else if (cur_valid)
                        begin
                            age_wdata = age_q + IW'(1);
                        end
                        if ((!cur_valid || evict_now) && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = tag_reg;
                        end
                    end
                    if (last_tag)
                    begin
                        pend_next = 1'b0;
                        if (!mode_reg)
                        begin
                            hit_total_next = hit_total_reg + 32'd1;
                            res_data_next  = hdata_reg;
                            state_next     = lbc_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = lbc_pkg::ST_INSERT;
                        end
                    end
                end
            end
            lbc_pkg::ST_INSERT:
            begin
                data_we = 1'b1;
                if (!found_reg)
                begin
                    key_we           = 1'b1;
                    set_valid        = 1'b1;
                    age_we           = 1'b1;
                    age_waddr        = free_idx_reg;
                    age_wdata        = '0;
                    count_next       = count_reg - evcnt_reg + CNT_W'(1);
                    evict_total_next = evict_total_reg + 32'(evcnt_reg);
                    res_ev_next      = 7'(evcnt_reg);
                end
                state_next = lbc_pkg::ST_DONE;
            end
            lbc_pkg::ST_DONE:
            begin
                state_next = lbc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lbc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lbc_pkg::ST_IDLE;
            ptr_reg         <= '0;
            issued_reg      <= 1'b0;
            pend_reg        <= 1'b0;
            found_reg       <= 1'b0;
            free_found_reg  <= 1'b0;
            evcnt_reg       <= '0;
            count_reg       <= '0;
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            ptr_reg         <= ptr_next;
            issued_reg      <= issued_next;
            pend_reg        <= pend_next;
            found_reg       <= found_next;
            free_found_reg  <= free_found_next;
            evcnt_reg       <= evcnt_next;
            count_reg       <= count_next;
            hit_total_reg   <= hit_total_next;
            miss_total_reg  <= miss_total_next;
            evict_total_reg <= evict_total_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tag_reg      <= tag_next;
        hidx_reg     <= hidx_next;
        hage_reg     <= hage_next;
        hdata_reg    <= hdata_next;
        free_idx_reg <= free_idx_next;
        res_hit_reg  <= res_hit_next;
        res_data_reg <= res_data_next;
        res_ev_reg   <= res_ev_next;
    end

    // Result ports
    assign busy        = (state_reg != lbc_pkg::ST_IDLE);
    assign done        = (state_reg == lbc_pkg::ST_DONE);
    assign hit         = res_hit_reg;
    assign read_data   = 64'(res_data_reg);
    assign evicted_now = res_ev_reg;
    assign hit_count   = hit_total_reg;
    assign miss_count  = miss_total_reg;
    assign evict_count = evict_total_reg;

endmodule

// ===== verif/lru_block_cache_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_block_cache_checker: result checker for the LRU block cache
// Follows accepted transactions and capacity writes, keeps a model of the
// entries and their recency, and checks every result field by field.
// ----------------------------------------------------------------------------
module lru_block_cache_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data,
    input  logic        start,
    input  logic        busy,
    input  logic        mode,
    input  logic [31:0] file_id,
    input  logic [63:0] offset,
    input  logic [31:0] frame_bytes,
    input  logic [63:0] write_data,
    input  logic        done,
    input  logic        hit,
    input  logic [63:0] read_data,
    input  logic [6:0]  evicted_now,
    input  logic [31:0] hit_count,
    input  logic [31:0] miss_count,
    input  logic [31:0] evict_count,
    output int          fail_count,
    output int          pending,
    output int          result_total,
    output int          hit_seen,
    output int          evict_seen
);

    localparam int SLOTS = lbc_pkg::DEPTH_DEFAULT;

    typedef struct packed {
        logic        hit;
        logic [63:0] read_data;
        logic [6:0]  evicted_now;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
        logic [31:0] evict_count;
    } lookup_result_t;

    lookup_result_t result_q[$];

    logic [6:0]  capacity;
    logic        slot_valid [SLOTS];
    logic [31:0] slot_file  [SLOTS];
    logic [63:0] slot_offset[SLOTS];
    logic [31:0] slot_frame [SLOTS];
    logic [63:0] slot_data  [SLOTS];
    int          slot_rank  [SLOTS];
    int          slot_used;
    logic [31:0] hit_total, miss_total, evict_total;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Move a slot to most recent, aging the newer ones.
    function automatic void promote(int idx);
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_rank[i] < slot_rank[idx])
                slot_rank[i]++;
        slot_rank[idx] = 0;
    endfunction

    function automatic lookup_result_t cache_access(logic op, logic [31:0] f,
            logic [63:0] off, logic [31:0] fr, logic [63:0] wd);
        lookup_result_t r;
        int idx;
        int lim;
        int n;
        idx = -1;
        n = 0;
        r = '0;
        lim = (capacity > SLOTS) ? SLOTS : capacity;
        for (int i = 0; i < SLOTS; i++)
            if (idx < 0 && slot_valid[i] && slot_file[i] == f && slot_offset[i] == off
                && slot_frame[i] == fr)
                idx = i;
        if (op == 1'b0)
        begin
            if (idx >= 0)
            begin
                r.hit = 1'b1;
                hit_total++;
                promote(idx);
                r.read_data = slot_data[idx];
            end
            else
                miss_total++;
        end
        else if (lim != 0)
        begin
            if (idx >= 0)
            begin
                r.hit = 1'b1;
                slot_data[idx] = wd;
                promote(idx);
            end
            else
            begin
                // Drop least recent entries until the new one fits.
                while (slot_used > lim - 1)
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_valid[i] && slot_rank[i] == slot_used - 1)
                        begin
                            slot_valid[i] = 1'b0;
                            slot_rank[i] = 0;
                            break;
                        end
                    slot_used--;
                    n++;
                end
                evict_total += n;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_valid[i])
                        slot_rank[i]++;
                for (int i = 0; i < SLOTS; i++)
                    if (!slot_valid[i])
                    begin
                        slot_valid[i] = 1'b1;
                        slot_file[i] = f;
                        slot_offset[i] = off;
                        slot_frame[i] = fr;
                        slot_data[i] = wd;
                        slot_rank[i] = 0;
                        slot_used++;
                        break;
                    end
            end
        end
        r.evicted_now = n[6:0];
        r.hit_count = hit_total;
        r.miss_count = miss_total;
        r.evict_count = evict_total;
        return r;
    endfunction

    // Track configuration, predict on accept, compare on done.
    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t want;
        if (!rst_n)
        begin
            capacity = lbc_pkg::CAPACITY_RESET;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_rank[i] = 0;
            end
            slot_used = 0;
            hit_total = '0;
            miss_total = '0;
            evict_total = '0;
            result_q.delete();
            pending = 0;
            fail_count = 0;
            result_total = 0;
            hit_seen = 0;
            evict_seen = 0;
        end
        else
        begin
            if (done)
            begin
                result_total++;
                if (result_q.size() == 0)
                begin
                    $display("ERROR %0t: result with nothing outstanding", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (hit) hit_seen++;
                    if (evicted_now != 0) evict_seen++;
                    if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
                    if (read_data !== want.read_data)
                        report_mismatch("read_data", read_data, want.read_data);
                    if (evicted_now !== want.evicted_now)
                        report_mismatch("evicted_now", evicted_now, want.evicted_now);
                    if (hit_count !== want.hit_count)
                        report_mismatch("hit_count", hit_count, want.hit_count);
                    if (miss_count !== want.miss_count)
                        report_mismatch("miss_count", miss_count, want.miss_count);
                    if (evict_count !== want.evict_count)
                        report_mismatch("evict_count", evict_count, want.evict_count);
                end
            end
            if (cfg_we)
                capacity = cfg_data;
            if (start && !busy)
                result_q.push_back(cache_access(mode, file_id, offset, frame_bytes,
                                                write_data));
            pending = result_q.size();
        end
    end
endmodule

// ===== verif/lru_block_cache_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_block_cache_tb: stimulus and verdict for the LRU block cache
// Runs directed and random gets and puts, mostly from a small key pool, over several
// capacity settings; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module lru_block_cache_tb;
    localparam int  RANDOM_ITEMS = 1280;
    localparam longint CYCLE_LIMIT = 3000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [6:0]  cfg_data;
    logic        start;
    logic        busy;
    logic        mode;
    logic [31:0] file_id;
    logic [63:0] offset;
    logic [31:0] frame_bytes;
    logic [63:0] write_data;
    logic        done;
    logic        hit;
    logic [63:0] read_data;
    logic [6:0]  evicted_now;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] evict_count;
    int          fail_count;
    int          pending;
    int          result_total;
    int          hit_seen;
    int          evict_seen;
    longint      cycle_count;

    // Key pool: random keys reused so that hits and evictions happen.
    logic [31:0] pool_file [96];
    logic [63:0] pool_offset[96];
    logic [31:0] pool_frame [96];

    lru_block_cache DUT (.*);

    lru_block_cache_checker checker_inst (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("lru_block_cache: mismatch");
            $finish;
        end
    end

    // Issue one transaction after a random gap; hold start for the one accepting edge.
    task automatic issue(input logic op, input logic [31:0] f, input logic [63:0] off,
                         input logic [31:0] fr, input logic [63:0] wd);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge clk);
        while (busy) @(negedge clk);
        mode = op;
        file_id = f;
        offset = off;
        frame_bytes = fr;
        write_data = wd;
        start = 1'b1;
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic issue_pool(input logic op, input int k);
        issue(op, pool_file[k], pool_offset[k], pool_frame[k],
              {$urandom, $urandom});
    endtask

    // Drain outstanding results, then let the block settle before a write.
    task automatic set_capacity(input logic [6:0] value);
        while (pending != 0) @(negedge clk);
        repeat (140) @(negedge clk);
        cfg_data = value;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        int k;
        int range;
        logic [6:0] caps[6];
        cycle_count = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        start = 1'b0;
        mode = 1'b0;
        file_id = '0;
        offset = '0;
        frame_bytes = '0;
        write_data = '0;
        for (int i = 0; i < 96; i++)
        begin
            pool_file[i] = (i < 8) ? {28'd0, i[3:0]} : $urandom;
            pool_offset[i] = {$urandom, $urandom};
            pool_frame[i] = (i < 8) ? 32'd4096 : $urandom;
        end
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes of the key and payload, miss, hit, update.
        issue(1'b0, '0, '0, '0, '0);
        issue(1'b1, '0, '0, '0, '1);
        issue(1'b0, '0, '0, '0, '0);
        issue(1'b1, '1, '1, '1, '1);
        issue(1'b0, '1, '1, '1, '0);
        issue(1'b1, '1, '1, '1, 64'h5555_5555_AAAA_AAAA);
        issue(1'b0, '1, '1, '1, '0);
        issue(1'b0, '1, '1, 32'hFFFF_FFFE, '0);
        // Small capacity: evict the least recent entry.
        set_capacity(7'd2);
        for (int i = 0; i < 4; i++) issue_pool(1'b1, i);
        issue_pool(1'b0, 2);
        issue_pool(1'b1, 4);
        issue_pool(1'b0, 3);
        // Capacity zero: puts ignored, gets still hit.
        set_capacity(7'd0);
        issue_pool(1'b1, 5);
        issue_pool(1'b0, 5);
        issue_pool(1'b0, 4);
        // Above the depth, then lowered below the count: next new put evicts many.
        set_capacity(7'd127);
        for (int i = 0; i < 70; i++) issue_pool(1'b1, i % 96);
        set_capacity(7'd1);
        issue_pool(1'b0, 60);
        issue_pool(1'b1, 90);

        // Random phases over several capacities.
        caps = '{7'd64, 7'd3, 7'd16, 7'd1, 7'd100, 7'd40};
        for (int p = 0; p < 6; p++)
        begin
            set_capacity(caps[p]);
            range = (p % 2 == 0) ? 95 : 11;
            for (int n = 0; n < RANDOM_ITEMS / 6; n++)
            begin
                k = $urandom_range(0, range);
                if ($urandom_range(0, 15) == 0)
                    issue(1'($urandom_range(0, 1)), $urandom, {$urandom, $urandom},
                          $urandom, {$urandom, $urandom});
                else
                    issue_pool(1'($urandom_range(0, 1)), k);
            end
        end
        set_capacity(7'd64);
        issue_pool(1'b0, 0);

        while (pending != 0) @(negedge clk);
        repeat (140) @(negedge clk);
        $display("covered %0d results, %0d hits, %0d with evictions across many capacities",
                 result_total, hit_seen, evict_seen);
        if (fail_count == 0)
            $display("lru_block_cache: match");
        else
            $display("lru_block_cache: mismatch");
        $finish;
    end
endmodule
